### hw/rtl/amrp_pkg.sv
// Package for the AT modem response parser: keyword table, result codes and phase type.
`default_nettype none

package amrp_pkg;

	// Line limit and derived counter width
	localparam int MAX_LINE = 127;
	localparam int CNT_W    = $clog2(MAX_LINE + 1);

	// Field widths
	localparam int CODE_W   = 4;
	localparam int SPEED_W  = 32;
	localparam int LEN_W    = 7;
	localparam int BYTE_W   = 8;

	// Keyword table geometry
	localparam int NUM_KW     = 13;
	localparam int KW_CONNECT = 2;
	localparam int KW_ECHO    = 12;
	localparam int KW_MAX_LEN = 12;
	localparam int KW_LEN_W   = $clog2(KW_MAX_LEN + 1);
	localparam logic [NUM_KW-1:0] ALL_KW = '1;

	// Result codes
	localparam logic [CODE_W-1:0] CODE_NONE    = 4'd0;
	localparam logic [CODE_W-1:0] CODE_OK      = 4'd1;
	localparam logic [CODE_W-1:0] CODE_CONNECT = 4'd2;
	localparam logic [CODE_W-1:0] CODE_RING    = 4'd3;
	localparam logic [CODE_W-1:0] CODE_NOCARR  = 4'd4;
	localparam logic [CODE_W-1:0] CODE_ERROR   = 4'd5;
	localparam logic [CODE_W-1:0] CODE_NODIAL  = 4'd6;
	localparam logic [CODE_W-1:0] CODE_BUSY    = 4'd7;
	localparam logic [CODE_W-1:0] CODE_NOANS   = 4'd8;
	localparam logic [CODE_W-1:0] CODE_RINGING = 4'd9;
	localparam logic [CODE_W-1:0] CODE_VOICE   = 4'd10;
	localparam logic [CODE_W-1:0] CODE_FAX     = 4'd11;
	localparam logic [CODE_W-1:0] CODE_TIMEOUT = 4'd12;

	localparam logic [SPEED_W-1:0] DEFAULT_SPEED = 32'd300;

	// Special characters
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	// Keyword text, right-justified: last character in the low byte
	localparam logic [BYTE_W*KW_MAX_LEN-1:0] KW_TEXT [NUM_KW] = '{
		(BYTE_W*KW_MAX_LEN)'("OK"),
		(BYTE_W*KW_MAX_LEN)'("CONNECT FAX"),
		(BYTE_W*KW_MAX_LEN)'("CONNECT"),
		(BYTE_W*KW_MAX_LEN)'("RING"),
		(BYTE_W*KW_MAX_LEN)'("NO CARRIER"),
		(BYTE_W*KW_MAX_LEN)'("ERROR"),
		(BYTE_W*KW_MAX_LEN)'("NO DIALTONE"),
		(BYTE_W*KW_MAX_LEN)'("NO DIAL TONE"),
		(BYTE_W*KW_MAX_LEN)'("BUSY"),
		(BYTE_W*KW_MAX_LEN)'("NO ANSWER"),
		(BYTE_W*KW_MAX_LEN)'("RINGING"),
		(BYTE_W*KW_MAX_LEN)'("VOICE"),
		(BYTE_W*KW_MAX_LEN)'("AT")
	};

	localparam logic [KW_LEN_W-1:0] KW_LEN [NUM_KW] = '{
		4'd2, 4'd11, 4'd7, 4'd4, 4'd10, 4'd5, 4'd11, 4'd12, 4'd4, 4'd9, 4'd7, 4'd5, 4'd2
	};

	// Prefix keywords keep matching past their own length
	localparam logic [NUM_KW-1:0] KW_PREFIX = 13'b1_0000_0000_0110;

	localparam logic [CODE_W-1:0] KW_CODE [NUM_KW] = '{
		CODE_OK, CODE_FAX, CODE_CONNECT, CODE_RING, CODE_NOCARR, CODE_ERROR,
		CODE_NODIAL, CODE_NODIAL, CODE_BUSY, CODE_NOANS, CODE_RINGING, CODE_VOICE,
		CODE_NONE
	};

	// Speed field parse phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BLANK,
		PH_SIGN,
		PH_DIGIT,
		PH_DONE
	} speed_phase_t;

endpackage

`default_nettype wire

### hw/rtl/at_modem_response_parser.sv
// A request is held in the input register; a line result it completes moves to the result register.
// Throughput: one request per cycle while the result register is not stalled; the keyword compare
// and the saturating multiply-by-ten accumulate of the speed field are both combinational.
// Backpressure: s_tready stays high while the input or result register is empty or m_tready is high.
// Reset (arst_n low, asynchronous): line state cleared, all keyword candidates set,
// input and result registers empty.
`default_nettype none

module at_modem_response_parser import amrp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tuser,   // [0] cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] connect_speed, [38:32] line_length, [39] is_echo
	output logic [3:0]       m_tuser    // [3:0] resp_code
);

	// Input register
	logic              valid_s1;
	logic              cmd_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Line state
	logic [CNT_W-1:0]   count_q;
	logic [NUM_KW-1:0]  match_q;
	logic [SPEED_W-1:0] accum_q;
	speed_phase_t       phase_q;
	logic               neg_q;

	// Result register
	logic               out_valid_q;
	logic [CODE_W-1:0]  code_q;
	logic [SPEED_W-1:0] speed_q;
	logic [LEN_W-1:0]   len_q;
	logic               echo_q;

	logic adv;
	logic proc;

	assign adv      = !out_valid_q || m_tready;
	assign proc     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	// Next-state and result logic
	logic               is_eol;
	logic               is_blank;
	logic               is_digit;
	logic [3:0]         dval;
	logic [35:0]        prod;
	logic [CNT_W-1:0]   cnt_n;
	logic [NUM_KW-1:0]  match_n;
	logic [SPEED_W-1:0] accum_n;
	speed_phase_t       phase_n;
	logic               neg_n;
	logic               emit;
	logic [CNT_W-1:0]   fin_cnt;
	logic [NUM_KW-1:0]  fin_match;
	logic [SPEED_W-1:0] fin_accum;
	speed_phase_t       fin_phase;
	logic               fin_neg;
	logic [CODE_W-1:0]  res_code;
	logic [SPEED_W-1:0] res_speed;
	logic               res_echo;
	logic               found;
	logic [6:0]         bit_idx;
	logic [3:0]         pos4;
	logic [BYTE_W-1:0]  kw_ch;

	always_comb begin
		is_eol   = (byte_s1 == CH_CR) || (byte_s1 == CH_LF);
		is_blank = (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB) ||
		           (byte_s1 == CH_VT) || (byte_s1 == CH_FF);
		is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		dval     = is_digit ? 4'(byte_s1 - CH_ZERO) : 4'd0;
		prod     = (36'(accum_q) << 3) + (36'(accum_q) << 1) + 36'(dval);
		pos4     = count_q[3:0];
		bit_idx  = '0;
		kw_ch    = '0;

		// Speed field phase
		accum_n = accum_q;
		phase_n = phase_q;
		neg_n   = neg_q;
		if (count_q == CNT_W'(7) && match_q[KW_CONNECT] && byte_s1 == CH_SPACE) begin
			phase_n = PH_BLANK;
		end else if (count_q >= CNT_W'(8)) begin
			unique case (phase_q)
				PH_BLANK: begin
					if (is_blank) begin
						phase_n = PH_BLANK;
					end else if (byte_s1 == CH_PLUS) begin
						phase_n = PH_SIGN;
					end else if (byte_s1 == CH_MINUS) begin
						phase_n = PH_SIGN;
						neg_n   = 1'b1;
					end else if (is_digit) begin
						phase_n = PH_DIGIT;
						accum_n = SPEED_W'(dval);
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_SIGN: begin
					if (is_digit) begin
						phase_n = PH_DIGIT;
						accum_n = SPEED_W'(dval);
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_DIGIT: begin
					if (is_digit) begin
						accum_n = (prod[35:32] != 4'd0) ? '1 : prod[31:0];
					end else begin
						phase_n = PH_DONE;
					end
				end
				default: phase_n = phase_q;
			endcase
		end

		// Drop keyword candidates that miss at this position
		match_n = match_q;
		for (int k = 0; k < NUM_KW; k++) begin
			if (count_q < CNT_W'(KW_LEN[k])) begin
				bit_idx = 7'(8 * (KW_LEN[k] - 4'd1 - pos4));
				kw_ch   = KW_TEXT[k][bit_idx +: BYTE_W];
				if (kw_ch != byte_s1)
					match_n[k] = 1'b0;
			end else if (!KW_PREFIX[k]) begin
				match_n[k] = 1'b0;
			end
		end
		cnt_n = count_q + CNT_W'(1);

		// Pick the state the finished line is judged on
		if (cmd_s1) begin
			emit = 1'b1;
		end else if (is_eol) begin
			emit = (count_q != '0);
		end else begin
			emit = (cnt_n >= CNT_W'(MAX_LINE));
		end
		if (!cmd_s1 && is_eol) begin
			fin_cnt   = count_q;
			fin_match = match_q;
			fin_accum = accum_q;
			fin_phase = phase_q;
			fin_neg   = neg_q;
		end else begin
			fin_cnt   = cnt_n;
			fin_match = match_n;
			fin_accum = accum_n;
			fin_phase = phase_n;
			fin_neg   = neg_n;
		end

		// Decode the result code, first matching keyword wins
		res_code = CODE_NONE;
		found    = 1'b0;
		for (int k = 0; k < KW_ECHO; k++) begin
			if (!found && fin_match[k] && fin_cnt >= CNT_W'(KW_LEN[k])) begin
				res_code = KW_CODE[k];
				found    = 1'b1;
			end
		end
		res_speed = '0;
		if (res_code == CODE_CONNECT) begin
			if (fin_phase == PH_IDLE)
				res_speed = DEFAULT_SPEED;
			else
				res_speed = fin_neg ? (SPEED_W'(0) - fin_accum) : fin_accum;
		end
		res_echo = fin_match[KW_ECHO] && (fin_cnt >= CNT_W'(2));
	end

	// Input register: load on accept, empty when consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// Line state: advance per request, clear on line end, full line or timeout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			match_q <= ALL_KW;
			accum_q <= '0;
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
		end else if (proc) begin
			if (emit) begin
				count_q <= '0;
				match_q <= ALL_KW;
				accum_q <= '0;
				phase_q <= PH_IDLE;
				neg_q   <= 1'b0;
			end else if (!is_eol) begin
				count_q <= cnt_n;
				match_q <= match_n;
				accum_q <= accum_n;
				phase_q <= phase_n;
				neg_q   <= neg_n;
			end
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			if (cmd_s1) begin
				code_q  <= CODE_TIMEOUT;
				speed_q <= '0;
				len_q   <= '0;
				echo_q  <= 1'b0;
			end else begin
				code_q  <= res_code;
				speed_q <= res_speed;
				len_q   <= fin_cnt[LEN_W-1:0];
				echo_q  <= res_echo;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = code_q;
	assign m_tdata  = {echo_q, len_q, speed_q};

	// Checks
	a_timeout_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == CODE_TIMEOUT) |-> (m_tdata == '0))
		else $error("timeout result carries payload");

	a_speed_connect: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != CODE_CONNECT) |-> (m_tdata[31:0] == '0))
		else $error("speed reported for a non-CONNECT line");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(MAX_LINE))
		else $error("line counter reached the line limit");

	a_timeout_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && cmd_s1) |=> (count_q == '0 && match_q == ALL_KW && phase_q == PH_IDLE))
		else $error("timeout did not clear the line state");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

`default_nettype wire

### verif/amrp_checker.sv
// Checker for the AT modem response parser: predicts each line result and compares the output stream.
`timescale 1ns / 100ps

module amrp_checker import amrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // [31:0] connect_speed, [38:32] line_length, [39] is_echo
	input  logic [3:0]  m_tuser,   // [3:0] resp_code
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [SPEED_W-1:0] speed;
		logic [LEN_W-1:0]   length;
		logic               echo;
	} line_result_t;

	line_result_t line_results[$];

	// Line state of the predictor
	int                 line_cnt;
	logic [NUM_KW-1:0]  kw_alive;
	logic [SPEED_W-1:0] speed_acc;
	speed_phase_t       speed_ph;
	logic               speed_neg;

	// Keyword table, in match priority order; the last entry marks a command echo
	function automatic string kw_text(input int k);
		case (k)
			0:  return "OK";
			1:  return "CONNECT FAX";
			2:  return "CONNECT";
			3:  return "RING";
			4:  return "NO CARRIER";
			5:  return "ERROR";
			6:  return "NO DIALTONE";
			7:  return "NO DIAL TONE";
			8:  return "BUSY";
			9:  return "NO ANSWER";
			10: return "RINGING";
			11: return "VOICE";
			default: return "AT";
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] kw_code(input int k);
		case (k)
			0:  return CODE_OK;
			1:  return CODE_FAX;
			2:  return CODE_CONNECT;
			3:  return CODE_RING;
			4:  return CODE_NOCARR;
			5:  return CODE_ERROR;
			6:  return CODE_NODIAL;
			7:  return CODE_NODIAL;
			8:  return CODE_BUSY;
			9:  return CODE_NOANS;
			10: return CODE_RINGING;
			11: return CODE_VOICE;
			default: return CODE_NONE;
		endcase
	endfunction

	function automatic logic kw_is_prefix(input int k);
		return k == 1 || k == KW_CONNECT || k == KW_ECHO;
	endfunction

	task automatic clear_line();
		line_cnt  = 0;
		kw_alive  = ALL_KW;
		speed_acc = '0;
		speed_ph  = PH_IDLE;
		speed_neg = 1'b0;
	endtask

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %0d, expected %0d", $time, field, got, want);
		fail_count++;
	endtask

	// Advance the speed field by one character after "CONNECT "
	task automatic take_speed_char(input logic [7:0] c);
		logic        digit;
		logic [3:0]  d;
		logic [63:0] wide;
		digit = c >= CH_ZERO && c <= CH_NINE;
		d = digit ? 4'(c - CH_ZERO) : 4'd0;
		case (speed_ph)
			PH_BLANK: begin
				if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
				end else if (c == CH_PLUS) begin
					speed_ph = PH_SIGN;
				end else if (c == CH_MINUS) begin
					speed_ph = PH_SIGN;
					speed_neg = 1'b1;
				end else if (digit) begin
					speed_ph = PH_DIGIT;
					speed_acc = 32'(d);
				end else begin
					speed_ph = PH_DONE;
				end
			end
			PH_SIGN: begin
				if (digit) begin
					speed_ph = PH_DIGIT;
					speed_acc = 32'(d);
				end else begin
					speed_ph = PH_DONE;
				end
			end
			PH_DIGIT: begin
				if (digit) begin
					// saturate the magnitude at all ones
					wide = {32'd0, speed_acc} * 64'd10 + 64'(d);
					speed_acc = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
				end else begin
					speed_ph = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	endtask

	// Decode the finished line and queue its result
	task automatic close_line();
		line_result_t r;
		logic         hit;
		string        word;
		r = '0;
		hit = 1'b0;
		for (int k = 0; k < KW_ECHO; k++) begin
			word = kw_text(k);
			if (!hit && kw_alive[k] && line_cnt >= word.len()) begin
				r.code = kw_code(k);
				hit = 1'b1;
			end
		end
		if (r.code == CODE_CONNECT) begin
			if (speed_ph == PH_IDLE)
				r.speed = DEFAULT_SPEED;
			else
				r.speed = speed_neg ? 32'd0 - speed_acc : speed_acc;
		end
		r.length = LEN_W'(line_cnt);
		r.echo = kw_alive[KW_ECHO] && line_cnt >= 2;
		line_results.push_back(r);
		clear_line();
	endtask

	// Predict the effect of one accepted request
	task automatic parse_request(input logic cmd, input logic [7:0] c);
		line_result_t r;
		int           pos;
		string        word;
		if (cmd) begin
			// timeout drops the partial line
			r = '0;
			r.code = CODE_TIMEOUT;
			line_results.push_back(r);
			clear_line();
		end else if (c == CH_CR || c == CH_LF) begin
			if (line_cnt != 0)
				close_line();
		end else begin
			pos = line_cnt;
			if (pos == 7 && kw_alive[KW_CONNECT] && c == CH_SPACE)
				speed_ph = PH_BLANK;
			else if (pos >= 8)
				take_speed_char(c);
			for (int k = 0; k < NUM_KW; k++) begin
				word = kw_text(k);
				if (kw_alive[k]) begin
					if (pos < word.len()) begin
						if (8'(word[pos]) != c)
							kw_alive[k] = 1'b0;
					end else if (!kw_is_prefix(k)) begin
						kw_alive[k] = 1'b0;
					end
				end
			end
			line_cnt = pos + 1;
			if (line_cnt >= MAX_LINE)
				close_line();
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		clear_line();
	end

	// Compare results first: a result never stems from a request of the same edge
	always @(posedge clk) begin
		line_result_t e;
		if (!arst_n) begin
			clear_line();
			line_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (line_results.size() == 0) begin
					report("result with nothing expected, resp_code", 32'(m_tuser), 32'd0);
				end else begin
					e = line_results.pop_front();
					if (m_tuser != e.code)
						report("resp_code", 32'(m_tuser), 32'(e.code));
					if (m_tdata[31:0] != e.speed)
						report("connect_speed", m_tdata[31:0], e.speed);
					if (m_tdata[38:32] != e.length)
						report("line_length", 32'(m_tdata[38:32]), 32'(e.length));
					if (m_tdata[39] != e.echo)
						report("is_echo", 32'(m_tdata[39]), 32'(e.echo));
				end
			end
			if (s_tvalid && s_tready)
				parse_request(s_tuser, s_tdata);
		end
		pending = line_results.size();
	end

endmodule

### verif/tb.sv
// Testbench top for the AT modem response parser: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb import amrp_pkg::*; ();

	localparam int RANDOM_ITEMS = 850;
	localparam int QUIET_ITEMS  = 700;
	localparam int STALL_LIMIT  = 2000;
	localparam int NUM_REPLY    = 16;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        s_tuser;   // [0] cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] connect_speed, [38:32] line_length, [39] is_echo
	logic [3:0]  m_tuser;   // [3:0] resp_code
	int          fail_count;
	int          pending;

	int n_sent;
	int stall_cycles;
	bit quiet;
	bit tx_calm;
	int tx_span;
	bit rx_calm;
	int rx_span;
	int rx_hold;

	at_modem_response_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	amrp_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result side in bursts; hold it ready in calm stretches and at the end
	always @(negedge clk) begin
		if (rx_span == 0) begin
			rx_calm = $urandom_range(0, 2) == 0;
			rx_span = $urandom_range(20, 200);
		end else begin
			rx_span--;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (!quiet && !rx_calm && $urandom_range(0, 4) == 0) begin
			rx_hold = $urandom_range(1, 6) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Replies and command echoes used to build lines
	function automatic string reply_word(input int k);
		case (k)
			0:  return "OK";
			1:  return "CONNECT";
			2:  return "CONNECT FAX";
			3:  return "RING";
			4:  return "NO CARRIER";
			5:  return "ERROR";
			6:  return "NO DIALTONE";
			7:  return "NO DIAL TONE";
			8:  return "BUSY";
			9:  return "NO ANSWER";
			10: return "RINGING";
			11: return "VOICE";
			12: return "AT";
			13: return "ATZ";
			14: return "ATDT5551234";
			default: return "ATH0";
		endcase
	endfunction

	// Send one request; called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic cmd, input logic [7:0] b);
		int gap;
		if (tx_span == 0) begin
			tx_calm = $urandom_range(0, 2) == 0;
			tx_span = $urandom_range(10, 100);
		end else begin
			tx_span--;
		end
		if (!quiet && !tx_calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	// Send text, with one character replaced by a random byte at bad_pos
	task automatic send_text(input string s, input int bad_pos);
		for (int i = 0; i < s.len(); i++)
			send_byte(1'b0, (i == bad_pos) ? 8'($urandom) : 8'(s[i]));
	endtask

	task automatic send_eol();
		case ($urandom_range(0, 3))
			0: send_byte(1'b0, CH_CR);
			1: send_byte(1'b0, CH_LF);
			2: begin
				send_byte(1'b0, CH_CR);
				send_byte(1'b0, CH_LF);
			end
			default: begin
				send_byte(1'b0, CH_LF);
				send_byte(1'b0, CH_CR);
			end
		endcase
	endtask

	task automatic send_blank();
		case ($urandom_range(0, 3))
			0: send_byte(1'b0, CH_SPACE);
			1: send_byte(1'b0, CH_TAB);
			2: send_byte(1'b0, CH_VT);
			default: send_byte(1'b0, CH_FF);
		endcase
	endtask

	// Speed field: blanks, optional sign, digits, sometimes trailing junk
	task automatic send_speed();
		int n;
		n = $urandom_range(0, 3);
		repeat (n) send_blank();
		case ($urandom_range(0, 3))
			0: send_byte(1'b0, CH_PLUS);
			1: send_byte(1'b0, CH_MINUS);
			default: begin
			end
		endcase
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
		repeat (n) send_byte(1'b0, 8'(CH_ZERO + $urandom_range(0, 9)));
		if ($urandom_range(0, 4) == 0)
			send_byte(1'b0, 8'($urandom_range(33, 126)));
	endtask

	// One random line: mostly replies, some noise, timeouts and full lines
	task automatic send_random_line();
		int    r;
		int    k;
		int    n;
		int    bad;
		string w;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			k = $urandom_range(0, NUM_REPLY - 1);
			w = reply_word(k);
			bad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w.len() - 1) : -1;
			send_text(w, bad);
			if (k == 1 && $urandom_range(0, 2) != 0) begin
				send_byte(1'b0, CH_SPACE);
				send_speed();
			end else if ($urandom_range(0, 9) == 0) begin
				send_byte(1'b0, 8'($urandom_range(32, 126)));
			end
			if ($urandom_range(0, 11) == 0)
				send_byte(1'b1, 8'($urandom));
			else
				send_eol();
		end else if (r < 75) begin
			send_text("CONNECT ", -1);
			send_speed();
			send_eol();
		end else if (r < 85) begin
			n = $urandom_range(1, 20);
			repeat (n) send_byte(1'b0, 8'($urandom));
			send_eol();
		end else if (r < 93) begin
			send_byte(1'b1, 8'($urandom));
		end else if (r < 95) begin
			n = $urandom_range(MAX_LINE - 2, MAX_LINE + 8);
			if ($urandom_range(0, 1) == 0) begin
				send_text("CONNECT 1", -1);
				n = n - 9;
			end
			repeat (n) send_byte(1'b0, 8'($urandom_range(32, 126)));
			send_eol();
		end else begin
			n = $urandom_range(1, 4);
			repeat (n) send_byte(1'b0, ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
		end
	endtask

	initial begin
		int base;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = 8'h00;
		m_tready = 1'b0;
		n_sent = 0;
		stall_cycles = 0;
		quiet = 1'b0;
		tx_calm = 1'b0;
		tx_span = 0;
		rx_calm = 1'b0;
		rx_span = 0;
		rx_hold = 0;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Leading CR/LF are skipped, then every reply and echo once
		send_byte(1'b0, CH_CR);
		send_byte(1'b0, CH_LF);
		for (int k = 0; k < NUM_REPLY; k++) begin
			send_text(reply_word(k), -1);
			send_eol();
		end

		// Speed field corners
		send_text("CONNECT 115200", -1);
		send_eol();
		send_text("CONNECT ", -1);
		send_byte(1'b0, CH_TAB);
		send_byte(1'b0, CH_VT);
		send_byte(1'b0, CH_FF);
		send_text("-2400", -1);
		send_eol();
		send_text("CONNECT +99999999999", -1);
		send_eol();
		send_text("CONNECT -99999999999", -1);
		send_eol();
		send_text("CONNECT 4294967295x1", -1);
		send_eol();
		send_text("CONNECT -", -1);
		send_eol();
		send_text("CONNECTED", -1);
		send_eol();
		send_text("CONNECT FAX 9600", -1);
		send_eol();
		send_text("OKAY", -1);
		send_eol();
		send_text("A", -1);
		send_eol();

		// NUL and all-ones bytes as plain characters
		send_byte(1'b0, 8'h00);
		send_byte(1'b0, 8'hFF);
		send_eol();

		// Timeout alone and in the middle of a line
		send_byte(1'b1, 8'hFF);
		send_text("CONN", -1);
		send_byte(1'b1, 8'h00);

		// Full line; the CR right after it is skipped as an empty line
		repeat (MAX_LINE) send_byte(1'b0, "X");
		send_byte(1'b0, CH_CR);
		send_text("OK", -1);
		send_eol();
		send_text("CONNECT 1", -1);
		repeat (MAX_LINE - 9) send_byte(1'b0, "9");
		send_byte(1'b0, CH_LF);

		// Random lines; no idling in the last stretch
		base = n_sent;
		while (n_sent - base < RANDOM_ITEMS) begin
			if (n_sent - base >= QUIET_ITEMS)
				quiet = 1'b1;
			send_random_line();
		end
		quiet = 1'b1;
		s_tvalid <= 1'b0;

		// Drain the remaining results
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
hw/rtl/amrp_pkg.sv
hw/rtl/at_modem_response_parser.sv
verif/amrp_checker.sv
verif/tb.sv
